@@ src/pcsc_pkg.sv @@
package pcsc_pkg;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_TEXT,
    KIND_ZTXT,
    KIND_TIME
  } kind_t;

  typedef enum logic [1:0] {
    TP_KEY,
    TP_METHOD,
    TP_VALUE
  } tphase_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_KEY,
    EV_VALUE,
    EV_COMMIT
  } event_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOT_PNG = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_CRC     = 3'd3;
  localparam logic [2:0] ST_TEXT    = 3'd4;
  localparam logic [2:0] ST_TIME    = 3'd5;

  localparam logic [31:0] MAX_LEN_RST = 32'h7FFF_FFFF;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

  localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
  localparam logic [31:0] TYPE_ZTXT = 32'h7A54_5874;
  localparam logic [31:0] TYPE_TIME = 32'h7449_4D45;

  localparam int TIME_LEN = 7;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  meta_byte;
    kind_t       chunk_kind;
    logic [15:0] time_year;
    logic [7:0]  time_month;
    logic [7:0]  time_day;
    logic [7:0]  time_hour;
    logic [7:0]  time_minute;
    logic [7:0]  time_second;
    logic [2:0]  status;
    logic        file_done;
  } pcsc_res_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4E;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0D;
      3'd5: v = 8'h0A;
      3'd6: v = 8'h1A;
      3'd7: v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/pcsc_parser.sv @@
module pcsc_parser
  import pcsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        step_en,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output pcsc_res_t   res
);

  logic [31:0] max_len_r;
  phase_t      phase_r,   phase_nxt;
  logic [31:0] pos_r,     pos_nxt;
  logic [31:0] len_r,     len_nxt;
  logic [31:0] type_r,    type_nxt;
  kind_t       class_r,   class_nxt;
  logic [31:0] crc_r,     crc_nxt;
  logic [31:0] stored_r,  stored_nxt;
  tphase_t     tphase_r,  tphase_nxt;
  logic        tbad_r,    tbad_nxt;
  logic [55:0] tb_r,      tb_nxt;
  logic [2:0]  err_r,     err_nxt;

  logic [2:0]  fail;
  logic        ok_end;
  logic [31:0] pos_inc;
  logic [55:0] tb_out;
  logic [2:0]  code;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    class_nxt  = class_r;
    crc_nxt    = crc_r;
    stored_nxt = stored_r;
    tphase_nxt = tphase_r;
    tbad_nxt   = tbad_r;
    tb_nxt     = tb_r;
    err_nxt    = err_r;
    fail       = ST_OK;
    ok_end     = 1'b0;
    pos_inc    = pos_r + 32'd1;
    tb_out     = '0;
    code       = ST_OK;
    res        = '0;

    case (phase_r)
      PH_SIG: begin
        if (in_byte != sig_byte(pos_r[2:0])) begin
          fail = ST_NOT_PNG;
        end else if (pos_r >= 32'd7) begin
          if (in_last) begin
            ok_end = 1'b1;
          end else begin
            phase_nxt = PH_LEN;
            pos_nxt   = '0;
          end
        end else begin
          pos_nxt = pos_inc;
          if (in_last) fail = ST_NOT_PNG;
        end
      end
      PH_LEN: begin
        len_nxt = {len_r[23:0], in_byte};
        if (pos_r >= 32'd3) begin
          phase_nxt = PH_TYPE;
          pos_nxt   = '0;
          crc_nxt   = CRC_INIT;
        end else begin
          pos_nxt = pos_inc;
        end
        if (in_last) fail = ST_TRUNC;
      end
      PH_TYPE: begin
        type_nxt = {type_r[23:0], in_byte};
        crc_nxt  = crc_byte(crc_r, in_byte);
        if (pos_r >= 32'd3) begin
          if (type_nxt == TYPE_TEXT)      class_nxt = KIND_TEXT;
          else if (type_nxt == TYPE_ZTXT) class_nxt = KIND_ZTXT;
          else if (type_nxt == TYPE_TIME) class_nxt = KIND_TIME;
          else                            class_nxt = KIND_OTHER;
          tphase_nxt = TP_KEY;
          tbad_nxt   = 1'b0;
          tb_nxt     = '0;
          pos_nxt    = '0;
          if (len_r > max_len_r) fail = ST_TRUNC;
          else phase_nxt = (len_r == 32'd0) ? PH_CRC : PH_DATA;
        end else begin
          pos_nxt = pos_inc;
        end
        if (in_last) fail = ST_TRUNC;
      end
      PH_DATA: begin
        crc_nxt = crc_byte(crc_r, in_byte);
        if (class_r == KIND_TEXT || class_r == KIND_ZTXT) begin
          case (tphase_r)
            TP_KEY: begin
              if (in_byte == 8'd0) begin
                tphase_nxt = (class_r == KIND_TEXT) ? TP_VALUE : TP_METHOD;
              end else begin
                res.event_res  = EV_KEY;
                res.meta_byte  = in_byte;
                res.chunk_kind = class_r;
              end
            end
            TP_METHOD: begin
              tbad_nxt   = (in_byte != 8'd0);
              tphase_nxt = TP_VALUE;
            end
            default: begin
              res.event_res  = EV_VALUE;
              res.meta_byte  = in_byte;
              res.chunk_kind = class_r;
            end
          endcase
        end else if (class_r == KIND_TIME && pos_r < 32'(TIME_LEN)) begin
          tb_nxt = {tb_r[47:0], in_byte};
        end
        pos_nxt = pos_inc;
        if (pos_inc == len_r) begin
          phase_nxt = PH_CRC;
          pos_nxt   = '0;
        end
        if (in_last) fail = ST_TRUNC;
      end
      PH_CRC: begin
        stored_nxt = {stored_r[23:0], in_byte};
        if (pos_r >= 32'd3) begin
          if (~crc_r != stored_nxt) begin
            code = ST_CRC;
          end else if (class_r == KIND_TEXT && tphase_r == TP_KEY) begin
            code = ST_TEXT;
          end else if (class_r == KIND_ZTXT && (tphase_r != TP_VALUE || tbad_r)) begin
            code = ST_TEXT;
          end else if (class_r == KIND_TIME && len_r != 32'(TIME_LEN)) begin
            code = ST_TIME;
          end
          if (code != ST_OK) begin
            fail = code;
          end else begin
            res.event_res  = EV_COMMIT;
            res.chunk_kind = class_r;
            if (class_r == KIND_TIME) tb_out = tb_r;
            if (in_last) begin
              ok_end = 1'b1;
            end else begin
              phase_nxt = PH_LEN;
              pos_nxt   = '0;
            end
          end
        end else begin
          pos_nxt = pos_inc;
          if (in_last) fail = ST_TRUNC;
        end
      end
      default: begin
        if (in_last) begin
          phase_nxt = PH_SIG;
          pos_nxt   = '0;
          err_nxt   = ST_OK;
        end else begin
          phase_nxt = PH_DRAIN;
        end
      end
    endcase

    res.time_year   = tb_out[55:40];
    res.time_month  = tb_out[39:32];
    res.time_day    = tb_out[31:24];
    res.time_hour   = tb_out[23:16];
    res.time_minute = tb_out[15:8];
    res.time_second = tb_out[7:0];
    res.status      = err_nxt;

    if (fail != ST_OK) begin
      res           = '0;
      res.status    = fail;
      res.file_done = 1'b1;
      if (in_last) begin
        phase_nxt = PH_SIG;
        pos_nxt   = '0;
        err_nxt   = ST_OK;
      end else begin
        phase_nxt = PH_DRAIN;
        err_nxt   = fail;
      end
    end else if (ok_end) begin
      res.file_done = 1'b1;
      res.status    = ST_OK;
      phase_nxt     = PH_SIG;
      pos_nxt       = '0;
      err_nxt       = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      max_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      pos_r    <= '0;
      len_r    <= '0;
      type_r   <= '0;
      class_r  <= KIND_OTHER;
      crc_r    <= CRC_INIT;
      stored_r <= '0;
      tphase_r <= TP_KEY;
      tbad_r   <= 1'b0;
      tb_r     <= '0;
      err_r    <= ST_OK;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      class_r  <= class_nxt;
      crc_r    <= crc_nxt;
      stored_r <= stored_nxt;
      tphase_r <= tphase_nxt;
      tbad_r   <= tbad_nxt;
      tb_r     <= tb_nxt;
      err_r    <= err_nxt;
    end
  end

  a_err_only_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_DRAIN) |-> (err_r == ST_OK))
    else $error("error code held outside drain");

  a_drain_has_err: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DRAIN) |-> (err_r != ST_OK))
    else $error("drain without error code");

  a_data_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (pos_r < len_r))
    else $error("data position past chunk length");

endmodule

@@ src/pcsc_out_skid.sv @@
module pcsc_out_skid
  import pcsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  pcsc_res_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output pcsc_res_t pop_data
);

  pcsc_res_t main_r,       main_nxt;
  pcsc_res_t skid_r,       skid_nxt;
  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  logic      push;
  logic      pop;

  assign push_ready = !skid_valid_r;
  assign push       = push_valid && push_ready;
  assign pop        = main_valid_r && pop_ready;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_r;

  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!main_valid_r || pop) begin
      main_valid_nxt = skid_valid_r || push;
      main_nxt       = skid_valid_r ? skid_r : push_data;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry without head entry");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (main_valid_r && !skid_valid_r && main_r == $past(skid_r)))
    else $error("skid entry not promoted in order");

endmodule

@@ src/png_chunk_stream_checker_core.sv @@
// channel | dir | handshake               | payload
// in      | in  | in_tvalid / in_tready   | tdata[7:0] file byte, tlast final byte
// out     | out | out_tvalid / out_tready | tdata status/time/meta, tuser event/kind,
//         |     |                         | tlast file done
// cfg     | in  | cfg_valid / cfg_ready   | cfg_data max chunk length
//
// One byte per cycle while in_tready is high; each accepted byte yields one result.
// Parsing step and CRC byte update sit between the parser state and the
// output register; a two-entry output buffer absorbs one extra result while
// the output stalls. Reset is synchronous; max length resets to 0x7FFFFFFF.
module png_chunk_stream_checker_core
  import pcsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] meta_byte, [23:8] time_year, [31:24] time_month,
                                  // [39:32] time_day, [47:40] time_hour,
                                  // [55:48] time_minute, [63:56] time_second,
                                  // [66:64] status, [71:67] zero
  output logic [3:0]  out_tuser,  // [1:0] event_res, [3:2] chunk_kind
  output logic        out_tlast,  // file_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  pcsc_res_t step_res;
  pcsc_res_t out_res;
  logic      step_en;

  assign cfg_ready = 1'b1;
  assign step_en   = in_tvalid && in_tready;

  pcsc_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .step_en  (step_en),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .res      (step_res)
  );

  pcsc_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (step_res),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (out_res)
  );

  assign out_tdata = {5'd0, out_res.status, out_res.time_second, out_res.time_minute,
                      out_res.time_hour, out_res.time_day, out_res.time_month,
                      out_res.time_year, out_res.meta_byte};
  assign out_tuser = {out_res.chunk_kind, out_res.event_res};
  assign out_tlast = out_res.file_done;

  a_event_clean_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res.event_res != EV_NONE) |-> (out_res.status == ST_OK))
    else $error("event with error status");

endmodule

@@ tb/png_chunk_stream_checker_core_test.sv @@
`timescale 1ns / 100ps

module png_chunk_stream_checker_core_test;
  import pcsc_pkg::*;

  localparam logic [63:0] PNG_MAGIC  = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] TYPE_IEND  = 32'h4945_4E44;
  localparam int          LONG_STALL = 250;

  typedef struct packed {
    logic [7:0] dat;
    logic       fin;
  } file_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] in_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;         // [7:0] meta, [23:8] year, [31:24] month, [39:32] day,
                                  // [47:40] hour, [55:48] minute, [63:56] second,
                                  // [66:64] status
  logic [3:0]  out_tuser;         // [1:0] event_res, [3:2] chunk_kind
  logic        out_tlast;         // file_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'd0;

  png_chunk_stream_checker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  file_byte_t  byte_q[$];
  pcsc_res_t   due_q[$];
  logic [7:0]  file_buf[$];
  logic [7:0]  chunk_body[$];
  logic [31:0] crc_tab[256];
  int          queued = 0;
  int          errors = 0;
  int          send_gap_pct = 0;
  int          recv_gap_pct = 0;
  logic        in_fire = 1'b0;
  logic        stall_req = 1'b0;
  int          stall_cnt = 0;

  // parser image
  phase_t      ph;
  kind_t       cls;
  tphase_t     tph;
  logic [31:0] fpos, clen, tbytes, crc, scrc, max_len;
  logic        tbad;
  logic [55:0] tim;
  logic [2:0]  err;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    return crc_tab[c[7:0] ^ b] ^ (c >> 8);
  endfunction

  function automatic pcsc_res_t parse_png_byte(input logic [7:0] b, input logic fin);
    event_t      ev;
    kind_t       kd;
    logic [7:0]  meta;
    logic [2:0]  fail, code, st;
    logic [55:0] tb;
    logic        done, ok_end;
    logic [31:0] pos;
    pcsc_res_t   r;
    ev = EV_NONE;
    kd = KIND_OTHER;
    meta = 8'd0;
    fail = ST_OK;
    tb = '0;
    done = 1'b0;
    ok_end = 1'b0;
    pos = fpos;
    case (ph)
      PH_SIG: begin
        if (b != PNG_MAGIC[8 * (7 - pos[2:0]) +: 8]) begin
          fail = ST_NOT_PNG;
        end else if (pos >= 7) begin
          if (fin) ok_end = 1'b1;
          else begin
            ph = PH_LEN;
            fpos = 0;
          end
        end else begin
          fpos = pos + 1;
          if (fin) fail = ST_NOT_PNG;
        end
      end
      PH_LEN: begin
        clen = {clen[23:0], b};
        if (pos >= 3) begin
          ph = PH_TYPE;
          fpos = 0;
          crc = CRC_INIT;
        end else fpos = pos + 1;
        if (fin) fail = ST_TRUNC;
      end
      PH_TYPE: begin
        tbytes = {tbytes[23:0], b};
        crc = crc_next(crc, b);
        if (pos >= 3) begin
          if (tbytes == TYPE_TEXT) cls = KIND_TEXT;
          else if (tbytes == TYPE_ZTXT) cls = KIND_ZTXT;
          else if (tbytes == TYPE_TIME) cls = KIND_TIME;
          else cls = KIND_OTHER;
          tph = TP_KEY;
          tbad = 1'b0;
          tim = '0;
          fpos = 0;
          if (clen > max_len) fail = ST_TRUNC;
          else if (clen == 0) ph = PH_CRC;
          else ph = PH_DATA;
        end else fpos = pos + 1;
        if (fin) fail = ST_TRUNC;
      end
      PH_DATA: begin
        crc = crc_next(crc, b);
        if (cls == KIND_TEXT || cls == KIND_ZTXT) begin
          if (tph == TP_KEY) begin
            if (b == 8'd0) begin
              if (cls == KIND_TEXT) tph = TP_VALUE;
              else tph = TP_METHOD;
            end else begin
              ev = EV_KEY;
              meta = b;
            end
          end else if (tph == TP_METHOD) begin
            tbad = (b != 8'd0);
            tph = TP_VALUE;
          end else begin
            ev = EV_VALUE;
            meta = b;
          end
          if (ev != EV_NONE) kd = cls;
        end else if (cls == KIND_TIME && pos < TIME_LEN) begin
          tim = {tim[47:0], b};
        end
        pos = pos + 1;
        fpos = pos;
        if (pos == clen) begin
          ph = PH_CRC;
          fpos = 0;
        end
        if (fin) fail = ST_TRUNC;
      end
      PH_CRC: begin
        scrc = {scrc[23:0], b};
        if (pos >= 3) begin
          code = ST_OK;
          if ((crc ^ CRC_INIT) != scrc) code = ST_CRC;
          else if (cls == KIND_TEXT && tph == TP_KEY) code = ST_TEXT;
          else if (cls == KIND_ZTXT && (tph != TP_VALUE || tbad)) code = ST_TEXT;
          else if (cls == KIND_TIME && clen != TIME_LEN) code = ST_TIME;
          if (code != ST_OK) begin
            fail = code;
          end else begin
            ev = EV_COMMIT;
            kd = cls;
            if (cls == KIND_TIME) tb = tim;
            if (fin) ok_end = 1'b1;
            else begin
              ph = PH_LEN;
              fpos = 0;
            end
          end
        end else begin
          fpos = pos + 1;
          if (fin) fail = ST_TRUNC;
        end
      end
      default: begin
        if (fin) begin
          ph = PH_SIG;
          fpos = 0;
          err = ST_OK;
        end else ph = PH_DRAIN;
      end
    endcase
    st = err;
    if (fail != ST_OK) begin
      ev = EV_NONE;
      meta = 8'd0;
      kd = KIND_OTHER;
      tb = '0;
      done = 1'b1;
      st = fail;
      err = fail;
      if (fin) begin
        ph = PH_SIG;
        fpos = 0;
        err = ST_OK;
      end else ph = PH_DRAIN;
    end else if (ok_end) begin
      done = 1'b1;
      st = ST_OK;
      ph = PH_SIG;
      fpos = 0;
      err = ST_OK;
    end
    r.event_res   = ev;
    r.meta_byte   = meta;
    r.chunk_kind  = kd;
    r.time_year   = tb[55:40];
    r.time_month  = tb[39:32];
    r.time_day    = tb[31:24];
    r.time_hour   = tb[23:16];
    r.time_minute = tb[15:8];
    r.time_second = tb[7:0];
    r.status      = st;
    r.file_done   = done;
    return r;
  endfunction

  task automatic chk(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // request side
  always @(negedge clk) begin : drive_bytes
    file_byte_t nb;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nb = byte_q.pop_front();
        in_tdata  <= nb.dat;
        in_tlast  <= nb.fin;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_cnt != 0) begin
      out_tready <= 1'b0;
      stall_cnt  <= stall_cnt - 1;
    end else if (stall_req) begin
      out_tready <= 1'b0;
      stall_cnt  <= LONG_STALL;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin : watch
    pcsc_res_t w;
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) due_q.push_back(parse_png_byte(in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          $error("result with nothing outstanding");
          errors++;
        end else begin
          w = due_q.pop_front();
          chk("event_res", w.event_res, out_tuser[1:0]);
          chk("chunk_kind", w.chunk_kind, out_tuser[3:2]);
          chk("meta_byte", w.meta_byte, out_tdata[7:0]);
          chk("time_year", w.time_year, out_tdata[23:8]);
          chk("time_month", w.time_month, out_tdata[31:24]);
          chk("time_day", w.time_day, out_tdata[39:32]);
          chk("time_hour", w.time_hour, out_tdata[47:40]);
          chk("time_minute", w.time_minute, out_tdata[55:48]);
          chk("time_second", w.time_second, out_tdata[63:56]);
          chk("status", w.status, out_tdata[66:64]);
          chk("tdata_pad", 16'd0, out_tdata[71:67]);
          chk("file_done", w.file_done, out_tlast);
        end
      end
    end
  end

  task automatic put_chunk(input logic [31:0] typ, input logic [31:0] len,
                           input bit bad_crc, input bit with_crc);
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 3; i >= 0; i--) file_buf.push_back(len[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) begin
      file_buf.push_back(typ[8 * i +: 8]);
      c = crc_next(c, typ[8 * i +: 8]);
    end
    foreach (chunk_body[i]) begin
      file_buf.push_back(chunk_body[i]);
      c = crc_next(c, chunk_body[i]);
    end
    c = c ^ CRC_INIT;
    if (bad_crc) c = c ^ (32'd1 << $urandom_range(31));
    if (with_crc) for (int i = 3; i >= 0; i--) file_buf.push_back(c[8 * i +: 8]);
  endtask

  // cut: number of bytes kept, 0 keeps the whole file
  task automatic send_file(input int cut);
    file_byte_t nb;
    int n;
    n = (cut > 0 && cut < file_buf.size()) ? cut : file_buf.size();
    for (int i = 0; i < n; i++) begin
      nb.dat = file_buf[i];
      nb.fin = (i == n - 1);
      byte_q.push_back(nb);
    end
    queued += n;
    file_buf.delete();
  endtask

  task automatic add_magic();
    for (int i = 7; i >= 0; i--) file_buf.push_back(PNG_MAGIC[8 * i +: 8]);
  endtask

  task automatic fill_text(input bit z);
    repeat ($urandom_range(0, 4)) chunk_body.push_back(8'($urandom_range(1, 255)));
    if ($urandom_range(9) != 0) begin
      chunk_body.push_back(8'd0);
      if (z) begin
        if ($urandom_range(9) == 0) return;
        chunk_body.push_back(8'(($urandom_range(7) == 0) ? $urandom_range(1, 255) : 0));
      end
      repeat ($urandom_range(0, 5)) chunk_body.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic rand_file();
    logic [31:0] typ;
    int          cut;
    int          nch;
    bit          huge;
    cut = 0;
    huge = 1'b0;
    if ($urandom_range(11) == 0) begin
      repeat ($urandom_range(1, 6)) file_buf.push_back(8'($urandom_range(255)));
      send_file(0);
      return;
    end
    add_magic();
    if ($urandom_range(15) == 0) file_buf[$urandom_range(7)] ^= 8'($urandom_range(1, 255));
    nch = $urandom_range(0, 3);
    for (int k = 0; k < nch && !huge; k++) begin
      chunk_body.delete();
      case ($urandom_range(3))
        0: begin
          typ = TYPE_TEXT;
          fill_text(1'b0);
        end
        1: begin
          typ = TYPE_ZTXT;
          fill_text(1'b1);
        end
        2: begin
          typ = TYPE_TIME;
          repeat (($urandom_range(7) == 0) ? $urandom_range(0, 10) : TIME_LEN)
            chunk_body.push_back(8'($urandom_range(255)));
        end
        default: begin
          typ = ($urandom_range(3) == 0) ? TYPE_IEND : $urandom;
          repeat ($urandom_range(0, 8)) chunk_body.push_back(8'($urandom_range(255)));
        end
      endcase
      if ($urandom_range(19) == 0) begin
        // declared length far beyond the bytes that follow
        huge = 1'b1;
        put_chunk(typ, $urandom | 32'h0001_0000, 1'b0, 1'b0);
      end else begin
        put_chunk(typ, chunk_body.size(), $urandom_range(15) == 0, 1'b1);
      end
    end
    if (!huge && $urandom_range(7) == 0) cut = $urandom_range(1, file_buf.size());
    send_file(cut);
  endtask

  task automatic rand_files(input int n);
    int start;
    start = queued;
    while (queued - start < n) rand_file();
  endtask

  task automatic wait_quiet();
    while (byte_q.size() != 0 || in_tvalid || due_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_max_len(input logic [31:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    max_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = i;
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      crc_tab[i] = c;
    end
    ph = PH_SIG;
    cls = KIND_OTHER;
    tph = TP_KEY;
    fpos = 0;
    clen = 0;
    tbytes = 0;
    crc = CRC_INIT;
    scrc = 0;
    tbad = 1'b0;
    tim = '0;
    err = ST_OK;
    max_len = MAX_LEN_RST;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_gap_pct = 9;
    recv_gap_pct = 71;
    // well-formed file with every chunk kind and extreme byte values
    add_magic();
    chunk_body = '{8'hFF, 8'h01, 8'h00, 8'h00, 8'hFF};
    put_chunk(TYPE_TEXT, chunk_body.size(), 1'b0, 1'b1);
    chunk_body = '{8'h7A, 8'h00, 8'h00, 8'h78, 8'h9C};
    put_chunk(TYPE_ZTXT, chunk_body.size(), 1'b0, 1'b1);
    chunk_body = '{8'h07, 8'hE8, 8'h0C, 8'h1F, 8'h17, 8'h3B, 8'h3C};
    put_chunk(TYPE_TIME, chunk_body.size(), 1'b0, 1'b1);
    chunk_body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    put_chunk(TYPE_TIME, chunk_body.size(), 1'b0, 1'b1);
    chunk_body.delete();
    put_chunk(TYPE_IEND, 0, 1'b0, 1'b1);
    send_file(0);
    // signature only
    add_magic();
    send_file(0);
    // wrong first byte, rest of file ignored
    file_buf = '{8'h00, 8'hFF};
    send_file(0);
    // file ends inside the signature
    file_buf = '{8'h89, 8'h50};
    send_file(0);
    rand_files(60);
    wait_quiet();

    set_max_len(32'hFFFF_FFFF);
    send_gap_pct = 71;
    recv_gap_pct = 9;
    rand_files(70);
    wait_quiet();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_max_len(32'd0);
    rand_files(30);
    wait_quiet();

    set_max_len(32'd10);
    rand_files(60);
    @(posedge clk) stall_req <= 1'b1;
    @(posedge clk) stall_req <= 1'b0;
    wait_quiet();

    set_max_len(32'h8000_0000);
    rand_files(40);
    wait_quiet();

    repeat (4) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
